/* hdl/rcp_pkg.sv */
// Shared types and constants of the command parser.
// Byte classes, event kinds, queue item and status structs, limit registers.
// No dependencies.
package rcp_pkg;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // width of the index and total fields of a result beat
    localparam int ARG_FIELD_BITS = 10;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_DIGIT,
        CLS_STAR,
        CLS_DOLLAR,
        CLS_MINUS,
        CLS_CR,
        CLS_LF
    } byte_class_t;

    typedef enum logic [1:0] {
        EV_ARG_BYTE = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_ERROR    = 2'd2
    } event_kind_t;

    typedef enum logic {
        REG_MAX_ARG_COUNT     = 1'b0,
        REG_MAX_STRING_LENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
    } rcp_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } rcp_queue_status_t;

    typedef struct packed {
        logic [9:0]  max_arg_count;
        logic [15:0] max_string_length;
    } rcp_limits_t;

endpackage

/* hdl/rcp_classify.sv */
// Front end: sorts each received byte into a class for the parser.
// Depends on rcp_pkg.
module rcp_classify
    import rcp_pkg::*;
(
    input  logic [7:0] data,
    output rcp_item_t  item
);

    always_comb
    begin
        item.data = data;
        if (data >= CH_ZERO && data <= CH_NINE)
        begin
            item.cls = CLS_DIGIT;
        end
        else
        begin
            case (data)
                CH_STAR:   item.cls = CLS_STAR;
                CH_DOLLAR: item.cls = CLS_DOLLAR;
                CH_MINUS:  item.cls = CLS_MINUS;
                CH_CR:     item.cls = CLS_CR;
                CH_LF:     item.cls = CLS_LF;
                default:   item.cls = CLS_OTHER;
            endcase
        end
    end

endmodule

/* hdl/rcp_queue.sv */
// Two-entry queue of classified bytes between the front end and the parser.
// Depends on rcp_pkg.
module rcp_queue
    import rcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rcp_item_t         in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output rcp_item_t         out_item,
    output rcp_queue_status_t status
);

    rcp_item_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign in_ready     = !status.full;
    assign out_valid    = !status.empty;
    assign out_item     = q_reg[rd_ptr_reg];
    assign push         = in_valid && in_ready;
    assign pop          = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hdl/rcp_parser.sv */
// Back end: command state machine, number accumulator and result register.
// Depends on rcp_pkg; fed from rcp_queue.
module rcp_parser
    import rcp_pkg::*;
#(
    parameter int ARG_INDEX_BITS = 10,
    parameter int LENGTH_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  rcp_limits_t limits,
    input  logic        item_valid,
    output logic        item_ready,
    input  rcp_item_t   item,
    output logic        out_valid,
    input  logic        out_ready,
    output event_kind_t out_kind,
    output logic [7:0]  out_byte,
    output logic [ARG_FIELD_BITS-1:0] out_index,
    output logic        out_last,
    output logic [ARG_FIELD_BITS-1:0] out_total
);

    localparam int ACC_BITS = ((ARG_INDEX_BITS > LENGTH_BITS) ? ARG_INDEX_BITS
                                                             : LENGTH_BITS) + 1;
    localparam int MUL_BITS = ACC_BITS + 4;
    localparam int CMP_BITS = (ACC_BITS > 16) ? ACC_BITS : 16;
    localparam int WIDE_IDX = (ARG_INDEX_BITS > ARG_FIELD_BITS) ? ARG_INDEX_BITS
                                                               : ARG_FIELD_BITS;
    localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_ARRAY,
        ST_NUM_FIRST,
        ST_NUM,
        ST_ARG_START,
        ST_LEN_LF,
        ST_DATA,
        ST_END
    } state_t;

    state_t                    state_reg, state_next;
    logic [ACC_BITS-1:0]       acc_reg, acc_next;
    logic                      minus_reg, minus_next;
    logic                      count_known_reg, count_known_next;
    logic [ARG_INDEX_BITS-1:0] args_expected_reg, args_expected_next;
    logic [ARG_INDEX_BITS-1:0] args_finished_reg, args_finished_next;
    logic [LENGTH_BITS-1:0]    str_len_reg, str_len_next;
    logic [LENGTH_BITS-1:0]    str_rcvd_reg, str_rcvd_next;

    logic                      out_valid_reg, out_valid_next;
    event_kind_t               out_kind_reg, out_kind_next;
    logic [7:0]                out_byte_reg, out_byte_next;
    logic [ARG_FIELD_BITS-1:0] out_index_reg, out_index_next;
    logic                      out_last_reg, out_last_next;
    logic [ARG_FIELD_BITS-1:0] out_total_reg, out_total_next;

    logic                      take;
    logic                      ev_valid;
    logic                      do_clear;
    logic                      clear_to_num;
    logic [MUL_BITS-1:0]       acc_wide;
    logic [MUL_BITS-1:0]       acc_prod;
    logic [ACC_BITS-1:0]       acc_sat;
    logic                      count_bad;
    logic                      len_bad;
    logic [ARG_INDEX_BITS-1:0] args_fin_inc;
    logic [LENGTH_BITS-1:0]    str_rcvd_inc;

    function automatic logic [ARG_FIELD_BITS-1:0] to_field(
        input logic [ARG_INDEX_BITS-1:0] x
    );
        logic [WIDE_IDX-1:0] w;
        w = WIDE_IDX'(x);
        return w[ARG_FIELD_BITS-1:0];
    endfunction

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;

    // times ten as two shifts and an add, add the digit, then saturate
    assign acc_wide = MUL_BITS'(acc_reg);
    assign acc_prod = (acc_wide << 3) + (acc_wide << 1) + MUL_BITS'(item.data[3:0]);
    assign acc_sat  = (acc_prod > MUL_BITS'(ACC_MAX)) ? ACC_MAX
                                                      : acc_prod[ACC_BITS-1:0];

    assign count_bad = minus_reg
                    || (CMP_BITS'(acc_reg) > CMP_BITS'(limits.max_arg_count))
                    || ((acc_reg >> ARG_INDEX_BITS) != '0);
    assign len_bad   = minus_reg
                    || (CMP_BITS'(acc_reg) > CMP_BITS'(limits.max_string_length))
                    || ((acc_reg >> LENGTH_BITS) != '0);

    assign args_fin_inc = args_finished_reg + ARG_INDEX_BITS'(1);
    assign str_rcvd_inc = str_rcvd_reg + LENGTH_BITS'(1);

    always_comb
    begin
        state_next         = state_reg;
        acc_next           = acc_reg;
        minus_next         = minus_reg;
        count_known_next   = count_known_reg;
        args_expected_next = args_expected_reg;
        args_finished_next = args_finished_reg;
        str_len_next       = str_len_reg;
        str_rcvd_next      = str_rcvd_reg;
        ev_valid           = 1'b0;
        out_kind_next      = EV_ARG_BYTE;
        out_byte_next      = 8'd0;
        out_index_next     = '0;
        out_last_next      = 1'b0;
        out_total_next     = '0;
        do_clear           = 1'b0;
        clear_to_num       = 1'b0;

        if (take)
        begin
            case (state_reg)
                ST_ARRAY:
                begin
                    if (item.cls == CLS_STAR)
                    begin
                        do_clear     = 1'b1;
                        clear_to_num = 1'b1;
                    end
                end
                ST_NUM_FIRST:
                begin
                    if (item.cls == CLS_DIGIT)
                    begin
                        acc_next   = ACC_BITS'(item.data[3:0]);
                        minus_next = 1'b0;
                        state_next = ST_NUM;
                    end
                    else if (item.cls == CLS_MINUS)
                    begin
                        acc_next   = '0;
                        minus_next = 1'b1;
                        state_next = ST_NUM;
                    end
                end
                ST_NUM:
                begin
                    if (item.cls == CLS_DIGIT)
                    begin
                        acc_next = acc_sat;
                    end
                    else if (item.cls == CLS_CR)
                    begin
                        acc_next   = '0;
                        minus_next = 1'b0;
                        if (!count_known_reg)
                        begin
                            if (count_bad)
                            begin
                                ev_valid      = 1'b1;
                                out_kind_next = EV_ERROR;
                                do_clear      = 1'b1;
                            end
                            else
                            begin
                                args_expected_next = acc_reg[ARG_INDEX_BITS-1:0];
                                args_finished_next = '0;
                                count_known_next   = 1'b1;
                                state_next = (acc_reg[ARG_INDEX_BITS-1:0] == '0)
                                           ? ST_END : ST_ARG_START;
                            end
                        end
                        else
                        begin
                            if (len_bad)
                            begin
                                ev_valid       = 1'b1;
                                out_kind_next  = EV_ERROR;
                                out_total_next = to_field(args_expected_reg);
                                do_clear       = 1'b1;
                            end
                            else
                            begin
                                str_len_next  = acc_reg[LENGTH_BITS-1:0];
                                str_rcvd_next = '0;
                                state_next    = ST_LEN_LF;
                            end
                        end
                    end
                end
                ST_ARG_START:
                begin
                    if (item.cls == CLS_DOLLAR)
                    begin
                        state_next = ST_NUM_FIRST;
                    end
                end
                ST_LEN_LF:
                begin
                    if (item.cls == CLS_LF)
                    begin
                        if (str_len_reg == '0)
                        begin
                            // empty argument: finish it without a byte beat
                            args_finished_next = args_fin_inc;
                            str_len_next       = '0;
                            str_rcvd_next      = '0;
                            state_next = (args_fin_inc == args_expected_reg)
                                       ? ST_END : ST_ARG_START;
                        end
                        else
                        begin
                            state_next = ST_DATA;
                        end
                    end
                end
                ST_DATA:
                begin
                    ev_valid       = 1'b1;
                    out_kind_next  = EV_ARG_BYTE;
                    out_byte_next  = item.data;
                    out_index_next = to_field(args_finished_reg);
                    out_last_next  = (str_rcvd_inc == str_len_reg);
                    out_total_next = to_field(args_expected_reg);
                    str_rcvd_next  = str_rcvd_inc;
                    if (str_rcvd_inc == str_len_reg)
                    begin
                        args_finished_next = args_fin_inc;
                        str_len_next       = '0;
                        str_rcvd_next      = '0;
                        state_next = (args_fin_inc == args_expected_reg)
                                   ? ST_END : ST_ARG_START;
                    end
                end
                ST_END:
                begin
                    if (item.cls == CLS_LF)
                    begin
                        ev_valid       = 1'b1;
                        out_kind_next  = EV_COMPLETE;
                        out_total_next = to_field(args_expected_reg);
                        do_clear       = 1'b1;
                    end
                end
                default:
                begin
                    do_clear = 1'b1;
                end
            endcase
        end

        if (do_clear)
        begin
            state_next         = clear_to_num ? ST_NUM_FIRST : ST_ARRAY;
            acc_next           = '0;
            minus_next         = 1'b0;
            count_known_next   = 1'b0;
            args_expected_next = '0;
            args_finished_next = '0;
            str_len_next       = '0;
            str_rcvd_next      = '0;
        end

        // load a new beat whenever the result register is free or being taken
        if (item_ready)
        begin
            out_valid_next = take && ev_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_ARRAY;
            acc_reg           <= '0;
            minus_reg         <= 1'b0;
            count_known_reg   <= 1'b0;
            args_expected_reg <= '0;
            args_finished_reg <= '0;
            str_len_reg       <= '0;
            str_rcvd_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_kind_reg      <= EV_ARG_BYTE;
            out_byte_reg      <= 8'd0;
            out_index_reg     <= '0;
            out_last_reg      <= 1'b0;
            out_total_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            acc_reg           <= acc_next;
            minus_reg         <= minus_next;
            count_known_reg   <= count_known_next;
            args_expected_reg <= args_expected_next;
            args_finished_reg <= args_finished_next;
            str_len_reg       <= str_len_next;
            str_rcvd_reg      <= str_rcvd_next;
            out_valid_reg     <= out_valid_next;
            if (take && ev_valid)
            begin
                out_kind_reg  <= out_kind_next;
                out_byte_reg  <= out_byte_next;
                out_index_reg <= out_index_next;
                out_last_reg  <= out_last_next;
                out_total_reg <= out_total_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;
    assign out_total = out_total_reg;

endmodule

/* hdl/resp_command_parser_top.sv */
// Top level of the command parser: limit registers, front end, queue, parser.
// Depends on rcp_pkg, rcp_classify, rcp_queue and rcp_parser.

// Parses '*'-counted arrays of '$'-length strings at one byte per clock while
// the output is not stalled. Each received byte is classified, held in a
// two-entry queue and handled by the parser, whose state update (times-ten
// accumulate with saturation and a limit compare) sets the rate. A byte passes
// the queue register, then its result beat is loaded into the result register.
// Each byte gives at most one result beat: an argument byte (tuser 0, tlast on
// the final byte of an argument), message complete (1) on the closing line
// feed, or a protocol error (2) on the carriage return ending a negative or
// over-limit number, after which the parser waits for the next '*'. Bytes not
// expected in the current state are dropped. Write the limits only while idle.
module resp_command_parser_top
    import rcp_pkg::*;
#(
    parameter int ARG_INDEX_BITS = 10,
    parameter int LENGTH_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] arg_byte, [17:8] arg_index, [27:18] arg_total
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [1:0] event_kind
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    rcp_limits_t       limits_reg;
    rcp_item_t         front_item;
    rcp_item_t         back_item;
    rcp_queue_status_t q_status;
    logic              back_valid;
    logic              back_ready;
    event_kind_t       out_kind;
    logic [7:0]        out_byte;
    logic [ARG_FIELD_BITS-1:0] out_index;
    logic [ARG_FIELD_BITS-1:0] out_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_arg_count     <= 10'd1023;
            limits_reg.max_string_length <= 16'd65535;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_MAX_ARG_COUNT:     limits_reg.max_arg_count     <= cfg_data[9:0];
                REG_MAX_STRING_LENGTH: limits_reg.max_string_length <= cfg_data;
                default:               limits_reg <= limits_reg;
            endcase
        end
    end

    rcp_classify u_classify (
        .data (s_tdata),
        .item (front_item)
    );

    rcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item),
        .status    (q_status)
    );

    rcp_parser #(
        .ARG_INDEX_BITS (ARG_INDEX_BITS),
        .LENGTH_BITS    (LENGTH_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .limits     (limits_reg),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .out_index  (out_index),
        .out_last   (m_tlast),
        .out_total  (out_total)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {4'd0, out_total, out_index, out_byte};

    // nothing queued and the last beat taken: no new beat can appear
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(q_status.empty) && $past(m_tready) |-> !m_tvalid)
        else $error("result beat without a queued byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !s_tready)
        else $error("byte accepted into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == EV_ARG_BYTE)
        else $error("last-of-argument flag on a non-byte event");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_ARG_BYTE |-> m_tdata[17:0] == 18'd0)
        else $error("byte or index set on a non-byte event");

endmodule
